@@ design/sine_oscillator_voice_macros.svh @@
// Assertion macros shared by the sine oscillator voice RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef SINE_OSCILLATOR_VOICE_MACROS_SVH
`define SINE_OSCILLATOR_VOICE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sov_pkg.sv @@
// Package for the sine oscillator voice: widths, codes, control structs,
// arithmetic helpers and the quarter-wave sine table. Depends on nothing.
package sov_pkg;

  // Oscillator geometry. The table depth must be a power of two.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 32;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_W            = IDX_W - 2;
  localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;

  // Sample and arithmetic widths.
  localparam int SMP_W  = 16;
  localparam int OPND_W = 18;
  localparam int PROD_W = 2 * OPND_W;
  localparam int RND_W  = PROD_W - 15;
  localparam int SUM_W  = RND_W + 1;
  localparam int RAD_W  = 31;
  localparam int ROOT_W = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 3'd0,
    CFG_AMP       = 3'd1,
    CFG_PAN       = 3'd2,
    CFG_CUT       = 3'd3,
    CFG_RES       = 3'd4,
    CFG_SLOW      = 3'd5,
    CFG_FAST      = 3'd6,
    CFG_MODE      = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_STEREO = 2'd2;

  // Reset values of registers and state.
  localparam logic [31:0]      RST_PHASE_INC = 32'd39370534;
  localparam logic [SMP_W-1:0] Q15_ONE       = 16'd32768;
  localparam logic [SMP_W-1:0] Q15_HALF      = 16'd16384;
  localparam logic [SMP_W-1:0] RST_SLOW      = 16'd328;
  localparam logic [SMP_W-1:0] RST_FAST      = 16'd3277;
  localparam logic [SMP_W-1:0] CUT_MIN       = 16'd33;
  localparam logic [SMP_W-1:0] CUT_MAX       = 16'd32735;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_START   = 3'd1,
    ST_MUL     = 3'd2,
    ST_WB      = 3'd3,
    ST_SQ_GO   = 3'd4,
    ST_SQ_WAIT = 3'd5,
    ST_OUT     = 3'd6
  } state_e;

  typedef enum logic [3:0] {
    OP_S_AMP = 4'd0,
    OP_S_PAN = 4'd1,
    OP_S_CUT = 4'd2,
    OP_S_RES = 4'd3,
    OP_FILT  = 4'd4,
    OP_RES   = 4'd5,
    OP_AMP   = 4'd6,
    OP_GL    = 4'd7,
    OP_GR    = 4'd8
  } op_e;

  typedef struct packed {
    logic capture;
    op_e  op;
    logic mul_en;
    logic wb_en;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic smooth;
    logic res_nz;
    logic stereo;
    logic sqrt_busy;
  } sts_t;

  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [PROD_W:0]   rsum_t;

  function automatic logic [SMP_W-1:0] cap_q15(input logic [SMP_W-1:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

  function automatic logic [SMP_W-1:0] clamp_cut(input logic [SMP_W-1:0] v);
    logic [SMP_W-1:0] r;
    r = v;
    if (v < CUT_MIN) r = CUT_MIN;
    if (v > CUT_MAX) r = CUT_MAX;
    return r;
  endfunction

  // Round to nearest, ties away from zero, dividing by 2^15 or 2^16.
  function automatic rnd_t round_shift(input prod_t p, input logic sh16);
    rsum_t h;
    rsum_t q;
    h = sh16 ? rsum_t'(32768) : rsum_t'(16384);
    if (p < 0) h = h - rsum_t'(1);
    q = rsum_t'(p) + h;
    return sh16 ? rnd_t'(q >>> 16) : rnd_t'(q >>> 15);
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input sum_t v);
    logic signed [SMP_W-1:0] r;
    if (v > sum_t'(32767))       r = 16'sh7FFF;
    else if (v < sum_t'(-32768)) r = 16'sh8000;
    else                         r = v[SMP_W-1:0];
    return r;
  endfunction

  // Clamp a smoothed value to 0..1.0.
  function automatic logic [SMP_W-1:0] clamp_unit(input sum_t v);
    logic [SMP_W-1:0] r;
    if (v < 0)                   r = '0;
    else if (v > sum_t'(32768))  r = Q15_ONE;
    else                         r = v[SMP_W-1:0];
    return r;
  endfunction

  // Quarter-wave sine magnitude for in-quadrant step j (1..QTR_DEPTH),
  // a seven-term Taylor series in Q30, evaluated at elaboration.
  function automatic logic [14:0] sine_qtr_entry(input int unsigned j);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned v;
    longint          acc;
    r    = 64'(j) << (30 - QTR_W);
    x    = (r * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    term = ((term * x2) >> 30) / 6;   acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 20;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 42;  acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 72;  acc = acc + longint'(term);
    term = ((term * x2) >> 30) / 110; acc = acc - longint'(term);
    term = ((term * x2) >> 30) / 156; acc = acc + longint'(term);
    s = (acc < 0) ? 64'd0 : 64'(acc);
    v = (s * 64'd32767 + 64'd536870912) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[14:0];
  endfunction

  typedef logic [14:0] qtr_tab_t [QTR_DEPTH];

  function automatic qtr_tab_t build_qtr();
    qtr_tab_t t;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      t[k] = sine_qtr_entry(k + 1);
    end
    return t;
  endfunction

  // Entry k holds the magnitude for in-quadrant step k+1; step zero is zero.
  localparam qtr_tab_t SINE_QTR = build_qtr();

endpackage

@@ design/sov_stream_if.sv @@
// Valid/ready channel interfaces for the voice's input and output words.
// Depends on sov_pkg for the sample width.
interface sov_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 smooth_now;
  logic signed [sov_pkg::SMP_W-1:0]     mix_left;
  logic signed [sov_pkg::SMP_W-1:0]     mix_right;

  modport source (output valid, output smooth_now, output mix_left, output mix_right,
                  input ready);
  modport sink   (input valid, input smooth_now, input mix_left, input mix_right,
                  output ready);
endinterface

interface sov_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sov_pkg::SMP_W-1:0]     out_left;
  logic signed [sov_pkg::SMP_W-1:0]     out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

@@ design/sov_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
// Depends on sov_pkg for the radicand and root widths.
module sov_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sov_pkg::RAD_W-1:0]   radicand_i,
  output logic                        busy_o,
  output logic [sov_pkg::ROOT_W-1:0]  root_o
);
  import sov_pkg::*;

  logic [RAD_W-1:0] rem_q, rem_d;
  logic [RAD_W-1:0] res_q, res_d;
  logic [RAD_W-1:0] bit_q, bit_d;
  logic [RAD_W:0]   trial;

  assign trial  = {1'b0, res_q} + {1'b0, bit_q};
  assign busy_o = |bit_q;
  assign root_o = res_q[ROOT_W-1:0];

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    if (start_i) begin
      rem_d = radicand_i;
      res_d = '0;
      bit_d = RAD_W'(1) << (RAD_W - 1);
    end else if (busy_o) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - trial[RAD_W-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

endmodule

@@ design/sov_datapath.sv @@
// Datapath of the voice: configuration and voice state, sine lookup,
// shared multiplier with rounding writeback, pan gain root and output word.
// Depends on sov_pkg and sov_isqrt.
module sov_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sov_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sov_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                smooth_now_i,
  input  logic signed [sov_pkg::SMP_W-1:0]    mix_left_i,
  input  logic signed [sov_pkg::SMP_W-1:0]    mix_right_i,
  input  sov_pkg::cmd_t                       cmd_i,
  output sov_pkg::sts_t                       sts_o,
  output logic signed [sov_pkg::SMP_W-1:0]    out_left_o,
  output logic signed [sov_pkg::SMP_W-1:0]    out_right_o
);
  import sov_pkg::*;

  typedef logic [QTR_W:0] qstep_t;

  // Configuration registers.
  logic [31:0]      phase_inc_q;
  logic [SMP_W-1:0] tgt_amp_q, tgt_pan_q, tgt_cut_q, tgt_res_q, slow_q, fast_q;
  logic [1:0]       mode_q;

  // Voice state.
  logic [PHASE_BITS-1:0]   phase_q;
  logic [SMP_W-1:0]        s_amp_q, s_pan_q, s_cut_q, s_res_q;
  logic signed [SMP_W-1:0] fmem_q;

  // Per-sample working registers.
  logic                    smooth_q;
  logic signed [SMP_W-1:0] ml_q, mr_q, x_q, out_l_q, out_r_q;
  prod_t                   prod_q;
  logic signed [17:0]      f_q;
  logic signed [16:0]      a_q, cl_q, cr_q;

  // Sine lookup from the top phase bits, using quarter-wave symmetry.
  logic [IDX_W-1:0]        idx;
  logic [1:0]              quad;
  logic [QTR_W-1:0]        low;
  qstep_t                  step;
  logic [14:0]             mag;
  logic signed [SMP_W-1:0] x_now;

  assign idx  = phase_q[PHASE_BITS-1 -: IDX_W];
  assign quad = idx[IDX_W-1 -: 2];
  assign low  = idx[QTR_W-1:0];
  assign step = quad[0] ? (qstep_t'(QTR_DEPTH) - {1'b0, low}) : {1'b0, low};
  assign mag  = (step == '0) ? '0 : SINE_QTR[QTR_W'(step - qstep_t'(1))];
  assign x_now = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Operand selection for the shared multiplier.
  opnd_t            opa, opb;
  logic [SMP_W-1:0] s_cur, tgt_cur, coef_cur;

  always_comb begin
    s_cur    = s_amp_q;
    tgt_cur  = tgt_amp_q;
    coef_cur = slow_q;
    case (cmd_i.op)
      OP_S_PAN: begin
        s_cur    = s_pan_q;
        tgt_cur  = tgt_pan_q;
      end
      OP_S_CUT: begin
        s_cur    = s_cut_q;
        tgt_cur  = tgt_cut_q;
        coef_cur = fast_q;
      end
      OP_S_RES: begin
        s_cur    = s_res_q;
        tgt_cur  = tgt_res_q;
        coef_cur = fast_q;
      end
      default: ;
    endcase
  end

  logic [ROOT_W-1:0] root;

  always_comb begin
    case (cmd_i.op)
      OP_FILT: begin
        opa = opnd_t'(x_q) - opnd_t'(fmem_q);
        opb = $signed({2'b00, clamp_cut(s_cut_q)});
      end
      OP_RES: begin
        opa = opnd_t'(x_q) - f_q;
        opb = $signed({2'b00, s_res_q});
      end
      OP_AMP: begin
        opa = opnd_t'(fmem_q);
        opb = $signed({2'b00, s_amp_q});
      end
      OP_GL: begin
        opa = opnd_t'(a_q);
        opb = $signed({2'b00, root});
      end
      OP_GR: begin
        opa = opnd_t'(a_q);
        opb = $signed({2'b00, root});
      end
      default: begin
        opa = $signed({2'b00, cap_q15(tgt_cur)}) - $signed({2'b00, s_cur});
        opb = $signed({2'b00, cap_q15(coef_cur)});
      end
    endcase
  end

  // Writeback arithmetic.
  rnd_t             rnd;
  sum_t             s_new, f_new, r_new;
  logic [SMP_W-1:0] s_clamped;

  assign rnd       = round_shift(prod_q, cmd_i.op == OP_RES);
  assign s_new     = $signed({6'b0, s_cur}) + sum_t'(rnd);
  assign s_clamped = clamp_unit(s_new);
  assign f_new     = sum_t'(fmem_q) + sum_t'(rnd);
  assign r_new     = sum_t'(f_q) + sum_t'(rnd);

  // Output mix.
  logic signed [16:0] add_l, add_r;
  sum_t               l_sum, r_sum;

  always_comb begin
    add_l = '0;
    add_r = '0;
    case (mode_q)
      MODE_STEREO: begin
        add_l = cl_q;
        add_r = cr_q;
      end
      MODE_MONO: add_l = a_q;
      default: ;
    endcase
  end

  assign l_sum = sum_t'(ml_q) + sum_t'(add_l);
  assign r_sum = sum_t'(mr_q) + sum_t'(add_r);

  // Pan gain root: left gain from 1.0 - pan, right gain from pan.
  logic [SMP_W-1:0] pan_side;
  logic [RAD_W-1:0] radicand;
  logic             sqrt_busy;

  assign pan_side = (cmd_i.op == OP_GL) ? SMP_W'({1'b0, Q15_ONE} - {1'b0, s_pan_q})
                                        : s_pan_q;
  assign radicand = {pan_side, 15'b0};

  sov_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (radicand),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // Configuration and voice state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= RST_PHASE_INC;
      tgt_amp_q   <= '0;
      tgt_pan_q   <= Q15_HALF;
      tgt_cut_q   <= Q15_ONE;
      tgt_res_q   <= '0;
      slow_q      <= RST_SLOW;
      fast_q      <= RST_FAST;
      mode_q      <= MODE_STEREO;
      phase_q     <= '0;
      s_amp_q     <= '0;
      s_pan_q     <= Q15_HALF;
      s_cut_q     <= Q15_ONE;
      s_res_q     <= '0;
      fmem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PHASE_INC: phase_inc_q <= cfg_data_i;
          CFG_AMP:       tgt_amp_q   <= cfg_data_i[SMP_W-1:0];
          CFG_PAN:       tgt_pan_q   <= cfg_data_i[SMP_W-1:0];
          CFG_CUT:       tgt_cut_q   <= cfg_data_i[SMP_W-1:0];
          CFG_RES:       tgt_res_q   <= cfg_data_i[SMP_W-1:0];
          CFG_SLOW:      slow_q      <= cfg_data_i[SMP_W-1:0];
          CFG_FAST:      fast_q      <= cfg_data_i[SMP_W-1:0];
          CFG_MODE:      mode_q      <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (cmd_i.wb_en) begin
        case (cmd_i.op)
          OP_S_AMP: s_amp_q <= s_clamped;
          OP_S_PAN: s_pan_q <= s_clamped;
          OP_S_CUT: s_cut_q <= s_clamped;
          OP_S_RES: s_res_q <= s_clamped;
          OP_FILT:  fmem_q  <= sat16(f_new);
          OP_RES:   fmem_q  <= sat16(r_new);
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        phase_q <= phase_q + PHASE_BITS'(phase_inc_q);
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      smooth_q <= smooth_now_i;
      ml_q     <= mix_left_i;
      mr_q     <= mix_right_i;
      x_q      <= x_now;
    end
    if (cmd_i.mul_en) begin
      prod_q <= opa * opb;
    end
    if (cmd_i.wb_en) begin
      case (cmd_i.op)
        OP_FILT: f_q  <= 18'(f_new);
        OP_AMP:  a_q  <= 17'(rnd);
        OP_GL:   cl_q <= 17'(rnd);
        OP_GR:   cr_q <= 17'(rnd);
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_l_q <= sat16(l_sum);
      out_r_q <= sat16(r_sum);
    end
  end

  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;

  assign sts_o.smooth    = smooth_q;
  assign sts_o.res_nz    = (s_res_q != '0);
  assign sts_o.stereo    = (mode_q == MODE_STEREO);
  assign sts_o.sqrt_busy = sqrt_busy;

endmodule

@@ design/sov_ctrl.sv @@
// Controller of the voice: sequences smoothing, filter, resonance, amplitude
// and pan steps over the datapath and owns the channel handshakes.
// Depends on sov_pkg and sine_oscillator_voice_macros.svh.
`include "sine_oscillator_voice_macros.svh"

module sov_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  sov_pkg::sts_t  sts_i,
  output sov_pkg::cmd_t  cmd_o
);
  import sov_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and next operation.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_MUL;
        op_d    = sts_i.smooth ? OP_S_AMP : OP_FILT;
      end
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        state_d = ST_MUL;
        case (op_q)
          OP_S_AMP: op_d = OP_S_PAN;
          OP_S_PAN: op_d = OP_S_CUT;
          OP_S_CUT: op_d = OP_S_RES;
          OP_S_RES: op_d = OP_FILT;
          OP_FILT:  op_d = sts_i.res_nz ? OP_RES : OP_AMP;
          OP_RES:   op_d = OP_AMP;
          OP_AMP: begin
            if (sts_i.stereo) begin
              op_d    = OP_GL;
              state_d = ST_SQ_GO;
            end else begin
              state_d = ST_OUT;
            end
          end
          OP_GL: begin
            op_d    = OP_GR;
            state_d = ST_SQ_GO;
          end
          default: state_d = ST_OUT;
        endcase
      end
      ST_SQ_GO: state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (!sts_i.sqrt_busy) state_d = ST_MUL;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = op_q;
    in_ready_o       = 1'b0;
    out_valid_d      = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_MUL:   cmd_o.mul_en     = 1'b1;
      ST_WB:    cmd_o.wb_en      = 1'b1;
      ST_SQ_GO: cmd_o.sqrt_start = 1'b1;
      ST_OUT: begin
        cmd_o.out_load = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_FILT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  `SOV_ASSERT_IMP(a_sqrt_start_idle, cmd_o.sqrt_start, !sts_i.sqrt_busy, "root unit started while busy")
  `SOV_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_START, "accepted word did not start")
  `SOV_ASSERT_IMP(a_wb_after_mul, state_q == ST_WB, $past(state_q) == ST_MUL, "writeback without a product")

endmodule

@@ design/sine_oscillator_voice.sv @@
// Top level of the sine oscillator voice: controller, datapath and ports.
// Depends on sov_pkg, sov_stream_if, sov_ctrl and sov_datapath.
//
//  Channel   Direction  Handshake            Word
//  in_ch_i   in         valid/ready          smooth_now, mix_left, mix_right
//  out_ch_o  out        valid/ready          out_left, out_right
//  cfg       in         cfg_we_i, no wait    cfg_idx_i, cfg_data_i (32 bits)
//
// A word's result can be taken after the start step, the filter and
// amplitude multiplies and the output load. Smoothing adds the amplitude,
// pan, cutoff and resonance smoothing multiplies, and resonance adds its
// own multiply. Stereo panning adds, for each of the two pan gains,
// a start step, a wait on the bit-serial square root and a multiply with
// its writeback. All multiplies use the shared 18 by 18 multiplier. Reset
// is asynchronous and active low; it restores the configuration registers
// and the voice state but not the working registers. A finished word
// waits in the output register while the next input word is taken; the
// datapath holds at the output step only if that register is still full.
module sine_oscillator_voice (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sov_in_if.sink                          in_ch_i,
  sov_out_if.source                       out_ch_o,
  input  logic                            cfg_we_i,
  input  logic [sov_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sov_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sov_pkg::*;

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  sov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, voice state and output word.
  sov_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .smooth_now_i (in_ch_i.smooth_now),
    .mix_left_i   (in_ch_i.mix_left),
    .mix_right_i  (in_ch_i.mix_right),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_left_o   (out_ch_o.out_left),
    .out_right_o  (out_ch_o.out_right)
  );

  assign in_ch_i.ready  = in_ready;
  assign out_ch_o.valid = out_valid;

endmodule
